// ===== rtl/slr_pkg.sv =====
// Package for the sparse logistic scorer: sizes, command codes, the queue entry type
// and the elaboration-time functions that build the sigmoid lookup table.
// Depends on nothing; every other file of the block but slr_ram uses it.
package slr_pkg;

    localparam int FEATURE_COUNT_DEF = 1024;
    localparam int SIGMOID_DEPTH_DEF = 1024;

    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 10;
    localparam int WEIGHT_W   = 24;
    localparam int ID_W       = 16;
    localparam int SCORE_W    = 32;
    localparam int PROB_W     = 16;
    localparam int FRAC_W     = 16;

    localparam logic [CMD_W-1:0] CMD_WRITE      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD        = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_FINISH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FINISH     = 2'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic [ID_W-1:0]            id;
        logic signed [WEIGHT_W-1:0] weight;
    } work_t;

    localparam logic [63:0] Q31_ONE  = 64'd1 << 31;
    localparam logic [63:0] Q31_HALF = 64'd1 << 30;

    // Restoring division, used only while the table is built at elaboration.
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], n[i]};
            if (rem >= d)
            begin
                rem = rem - d;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Alternating Taylor series of exp(-r), r in Q1.31.
    function automatic logic [63:0] exp_series(input logic [63:0] r);
        logic [63:0] term;
        logic [63:0] sum;
        term = Q31_ONE;
        sum  = Q31_ONE;
        for (int i = 1; i <= 16; i++)
        begin
            term = udiv((term * r) >> 31, 64'(i));
            if ((i % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] exp_neg(input logic [63:0] x);
        logic [63:0] m;
        logic [63:0] r;
        logic [63:0] h;
        logic [63:0] e;
        m = x >> 30;
        r = x & (Q31_HALF - 64'd1);
        h = exp_series(Q31_HALF);
        e = Q31_ONE;
        for (int j = 0; j < 64; j++)
        begin
            if (64'(j) < m)
                e = (e * h + Q31_HALF) >> 31;
        end
        return (e * exp_series(r) + Q31_HALF) >> 31;
    endfunction

    // Table entry k stands for x = -8 + 16k/depth; returns sigmoid(x) as Q0.16.
    function automatic logic [PROB_W-1:0] sigmoid_entry(input longint k, input longint depth);
        longint      num;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] p;
        num = 16 * k - 8 * depth;
        a = (num < 0) ? 64'(-num) : 64'(num);
        x = udiv(a << 31, 64'(depth));
        e = exp_neg(x);
        d = Q31_ONE + e;
        if (num >= 0)
            p = udiv((64'd1 << 47) + (d >> 1), d);
        else
            p = udiv((e << 16) + (d >> 1), d);
        if (p < 64'd1)
            p = 64'd1;
        if (p > 64'd65535)
            p = 64'd65535;
        return p[PROB_W-1:0];
    endfunction

endpackage

// ===== rtl/sparse_logistic_scorer_top.sv =====
// Top level of the sparse logistic-regression scorer.
// Depends on slr_pkg, slr_front, slr_queue and slr_back.
//
// The scorer takes one item per clock cycle, with no bubbles, for any mix of
// commands, while the output is not stalled. A weight write takes effect for
// every item accepted after it. An add reads its weight from the weight RAM at
// the acceptance edge and passes through a four-entry queue to the accumulator,
// which adds and saturates combinationally into its register, so that adds of
// the same instance follow each other directly. A finishing command passes, in
// order, the queue write, the accumulator and its finish register, then the
// sigmoid table read and the output register. Output stalls fill the queue and
// then hold off input. The weight RAM has no reset; reading an unwritten weight
// gives an undefined score. The sigmoid table is a ROM built at elaboration.
module sparse_logistic_scorer_top #(
    parameter int FEATURE_COUNT = slr_pkg::FEATURE_COUNT_DEF,
    parameter int SIGMOID_DEPTH = slr_pkg::SIGMOID_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [slr_pkg::CMD_W-1:0]           command,
    input  logic [slr_pkg::INDEX_W-1:0]         feature_index,
    input  logic signed [slr_pkg::WEIGHT_W-1:0] weight_value,
    input  logic [slr_pkg::ID_W-1:0]            instance_id,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [slr_pkg::ID_W-1:0]            result_instance,
    output logic signed [slr_pkg::SCORE_W-1:0]  score_out,
    output logic [slr_pkg::PROB_W-1:0]          probability
);

    logic                         push_valid;
    slr_pkg::work_t               push_item;
    logic                         pop;
    logic                         head_valid;
    slr_pkg::work_t               head_item;
    logic [slr_pkg::QCNT_W-1:0]   queue_free;

    slr_front #(
        .FEATURE_COUNT (FEATURE_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .feature_index (feature_index),
        .weight_value  (weight_value),
        .instance_id   (instance_id),
        .queue_free    (queue_free),
        .push_valid    (push_valid),
        .push_item     (push_item)
    );

    slr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .queue_free (queue_free)
    );

    slr_back #(
        .SIGMOID_DEPTH (SIGMOID_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (head_valid),
        .head_item       (head_item),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .result_instance (result_instance),
        .score_out       (score_out),
        .probability     (probability)
    );

endmodule

// ===== rtl/slr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module slr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/slr_sigmoid_rom.sv =====
// Sigmoid lookup ROM with a registered read; contents are built at elaboration.
// Depends on slr_pkg for the table entry function.
module slr_sigmoid_rom #(
    parameter int DEPTH = slr_pkg::SIGMOID_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [$clog2(DEPTH)-1:0]    addr,
    output logic [slr_pkg::PROB_W-1:0]  data_reg
);

    typedef logic [slr_pkg::PROB_W-1:0] rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t tbl;
        for (int k = 0; k < DEPTH; k++)
        begin
            tbl[k] = slr_pkg::sigmoid_entry(longint'(k), longint'(DEPTH));
        end
        return tbl;
    endfunction

    localparam rom_t SIG_ROM = build_rom();

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= SIG_ROM[addr];
    end

endmodule

// ===== rtl/slr_front.sv =====
// Front end: accepts items, writes weights, starts weight reads and passes scoring
// work into the queue. Depends on slr_pkg and slr_ram.
module slr_front #(
    parameter int FEATURE_COUNT = slr_pkg::FEATURE_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [slr_pkg::CMD_W-1:0]           command,
    input  logic [slr_pkg::INDEX_W-1:0]         feature_index,
    input  logic signed [slr_pkg::WEIGHT_W-1:0] weight_value,
    input  logic [slr_pkg::ID_W-1:0]            instance_id,
    input  logic [slr_pkg::QCNT_W-1:0]          queue_free,
    output logic                                push_valid,
    output slr_pkg::work_t                      push_item
);

    localparam int AW = $clog2(FEATURE_COUNT);

    logic                          in_fire;
    logic [31:0]                   idx_ext;
    logic                          in_range;
    logic [AW-1:0]                 addr;
    logic                          is_add;
    logic                          wr_en;
    logic                          rd_en;
    logic [slr_pkg::WEIGHT_W-1:0]  ram_q;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [slr_pkg::CMD_W-1:0]     s1_cmd_reg;
    logic [slr_pkg::ID_W-1:0]      s1_id_reg;
    logic                          s1_hit_reg;

    assign in_ready = queue_free > slr_pkg::QCNT_W'(s1_valid_reg);
    assign in_fire  = in_valid && in_ready;
    assign idx_ext  = 32'(feature_index);
    assign in_range = idx_ext < 32'(FEATURE_COUNT);
    assign addr     = idx_ext[AW-1:0];
    assign is_add   = (command == slr_pkg::CMD_ADD) || (command == slr_pkg::CMD_ADD_FINISH);
    assign wr_en    = in_fire && (command == slr_pkg::CMD_WRITE) && in_range;
    assign rd_en    = in_fire && is_add && in_range;

    slr_ram #(
        .WIDTH (slr_pkg::WEIGHT_W),
        .DEPTH (FEATURE_COUNT)
    ) u_weight_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (weight_value),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_data (ram_q)
    );

    assign s1_valid_next = in_fire && (command != slr_pkg::CMD_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg <= command;
            s1_id_reg  <= instance_id;
            s1_hit_reg <= is_add && in_range;
        end
    end

    assign push_valid       = s1_valid_reg;
    assign push_item.cmd    = s1_cmd_reg;
    assign push_item.id     = s1_id_reg;
    assign push_item.weight = s1_hit_reg ? $signed(ram_q) : '0;

endmodule

// ===== rtl/slr_queue.sv =====
// Short queue of scoring work between the front end and the back end.
// Depends on slr_pkg for the entry type and depth.
module slr_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_valid,
    input  slr_pkg::work_t             push_item,
    input  logic                       pop,
    output logic                       head_valid,
    output slr_pkg::work_t             head_item,
    output logic [slr_pkg::QCNT_W-1:0] queue_free
);

    slr_pkg::work_t                entries [slr_pkg::QUEUE_DEPTH];
    logic [slr_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [slr_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [slr_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [slr_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [slr_pkg::QCNT_W-1:0]    count_reg;
    logic [slr_pkg::QCNT_W-1:0]    count_next;
    logic                          do_pop;

    assign head_valid = count_reg != '0;
    assign head_item  = entries[rd_ptr_reg];
    assign queue_free = slr_pkg::QCNT_W'(slr_pkg::QUEUE_DEPTH) - count_reg;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid)
            wr_ptr_next = (wr_ptr_reg == slr_pkg::QPTR_W'(slr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == slr_pkg::QPTR_W'(slr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (push_valid && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push_valid && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
            entries[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/slr_back.sv =====
// Back end: accumulates weights with saturation, finishes instances and looks up
// the sigmoid. Depends on slr_pkg and slr_sigmoid_rom.
module slr_back #(
    parameter int SIGMOID_DEPTH = slr_pkg::SIGMOID_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  slr_pkg::work_t                     head_item,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [slr_pkg::ID_W-1:0]           result_instance,
    output logic signed [slr_pkg::SCORE_W-1:0] score_out,
    output logic [slr_pkg::PROB_W-1:0]         probability
);

    localparam int IW = $clog2(SIGMOID_DEPTH);
    localparam int DW = $clog2(SIGMOID_DEPTH + 1);
    localparam int TW = slr_pkg::FRAC_W + 4;

    logic signed [slr_pkg::SCORE_W-1:0] acc_reg;
    logic signed [slr_pkg::SCORE_W-1:0] acc_next;
    logic signed [slr_pkg::SCORE_W:0]   sum;
    logic signed [slr_pkg::SCORE_W-1:0] sat_sum;
    logic signed [slr_pkg::SCORE_W-1:0] fin_score;
    logic                               finishing;

    logic                               b1_valid_reg;
    logic                               b1_valid_next;
    logic [slr_pkg::ID_W-1:0]           b1_id_reg;
    logic signed [slr_pkg::SCORE_W-1:0] b1_score_reg;
    logic                               b1_ready;

    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               out_adv;
    logic [slr_pkg::ID_W-1:0]           out_id_reg;
    logic signed [slr_pkg::SCORE_W-1:0] out_score_reg;

    logic signed [slr_pkg::SCORE_W:0]   shifted;
    logic [TW+DW-1:0]                   prod;
    logic [IW-1:0]                      rom_addr;

    assign sum = {acc_reg[slr_pkg::SCORE_W-1], acc_reg} +
                 {{(slr_pkg::SCORE_W + 1 - slr_pkg::WEIGHT_W){head_item.weight[slr_pkg::WEIGHT_W-1]}},
                  head_item.weight};

    always_comb
    begin
        if (sum[slr_pkg::SCORE_W] != sum[slr_pkg::SCORE_W-1])
            sat_sum = sum[slr_pkg::SCORE_W] ? {1'b1, {(slr_pkg::SCORE_W-1){1'b0}}}
                                            : {1'b0, {(slr_pkg::SCORE_W-1){1'b1}}};
        else
            sat_sum = sum[slr_pkg::SCORE_W-1:0];
    end

    assign out_adv  = !out_valid_reg || out_ready;
    assign b1_ready = !b1_valid_reg || out_adv;

    always_comb
    begin
        pop       = 1'b0;
        finishing = 1'b0;
        acc_next  = acc_reg;
        fin_score = acc_reg;
        unique case (head_item.cmd)
            slr_pkg::CMD_ADD:
            begin
                pop = head_valid;
                if (head_valid)
                    acc_next = sat_sum;
            end
            slr_pkg::CMD_ADD_FINISH:
            begin
                pop       = head_valid && b1_ready;
                finishing = pop;
                fin_score = sat_sum;
                if (pop)
                    acc_next = '0;
            end
            slr_pkg::CMD_FINISH:
            begin
                pop       = head_valid && b1_ready;
                finishing = pop;
                if (pop)
                    acc_next = '0;
            end
            default:
            begin
                pop = head_valid;
            end
        endcase
    end

    assign b1_valid_next  = finishing ? 1'b1 : (b1_ready ? 1'b0 : b1_valid_reg);
    assign out_valid_next = out_adv ? b1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finishing)
        begin
            b1_id_reg    <= head_item.id;
            b1_score_reg <= fin_score;
        end
        if (out_adv && b1_valid_reg)
        begin
            out_id_reg    <= b1_id_reg;
            out_score_reg <= b1_score_reg;
        end
    end

    assign shifted = {b1_score_reg[slr_pkg::SCORE_W-1], b1_score_reg} +
                     (slr_pkg::SCORE_W + 1)'(8 << slr_pkg::FRAC_W);
    assign prod    = (TW + DW)'(shifted[TW-1:0]) * (TW + DW)'(SIGMOID_DEPTH);

    always_comb
    begin
        if (shifted[slr_pkg::SCORE_W])
            rom_addr = '0;
        else if (shifted[slr_pkg::SCORE_W-1:TW] != '0)
            rom_addr = IW'(SIGMOID_DEPTH - 1);
        else
            rom_addr = prod[TW +: IW];
    end

    slr_sigmoid_rom #(
        .DEPTH (SIGMOID_DEPTH)
    ) u_rom (
        .clk      (clk),
        .en       (out_adv && b1_valid_reg),
        .addr     (rom_addr),
        .data_reg (probability)
    );

    assign out_valid       = out_valid_reg;
    assign result_instance = out_id_reg;
    assign score_out       = out_score_reg;

endmodule
